// ===== rtl/core/pas_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Paxos acceptor slot table: action, reply and error codes,
// slot entry and result types. No dependencies.
package pas_pkg;

   localparam int VALUE_W = 32;

   localparam logic [1:0] ACT_PREPARE = 2'd0;
   localparam logic [1:0] ACT_ACCEPT  = 2'd1;
   localparam logic [1:0] ACT_COMMIT  = 2'd2;
   localparam logic [1:0] ACT_NONE    = 2'd3;

   localparam logic [1:0] KIND_PREPARE = 2'd0;
   localparam logic [1:0] KIND_ACCEPT  = 2'd1;
   localparam logic [1:0] KIND_EXEC    = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_STALE      = 3'd1;
   localparam logic [2:0] ERR_NOT_ABOVE  = 3'd2;
   localparam logic [2:0] ERR_EXECUTED   = 3'd3;
   localparam logic [2:0] ERR_OUT_WINDOW = 3'd4;

   typedef struct packed {
      logic [VALUE_W-1:0] seen;
      logic [VALUE_W-1:0] accepted;
      logic               committed;
      logic [VALUE_W-1:0] command;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [1:0]         reply_kind;
      logic [VALUE_W-1:0] seen_ballot;
      logic [VALUE_W-1:0] executed_slot;
      logic [VALUE_W-1:0] executed_command;
      logic [2:0]         error_code;
      logic               last;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic [1:0] kind,
                                        input logic [VALUE_W-1:0] seen,
                                        input logic [VALUE_W-1:0] xslot,
                                        input logic [VALUE_W-1:0] xcmd,
                                        input logic [2:0] code,
                                        input logic last);
      rsp_type r;
      r.reply_kind       = kind;
      r.seen_ballot      = seen;
      r.executed_slot    = xslot;
      r.executed_command = xcmd;
      r.error_code       = code;
      r.last             = last;
      return r;
   endfunction

endpackage

// ===== rtl/core/pas_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the acceptor's request and response.
// Depends on pas_pkg.
interface pas_req_if;
   import pas_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [VALUE_W-1:0] slot;
   logic [VALUE_W-1:0] ballot;
   logic [VALUE_W-1:0] command_handle;
   modport source(output valid, action, slot, ballot, command_handle, input ready);
   modport sink(input valid, action, slot, ballot, command_handle, output ready);
endinterface

interface pas_rsp_if;
   import pas_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         reply_kind;
   logic [VALUE_W-1:0] seen_ballot;
   logic [VALUE_W-1:0] executed_slot;
   logic [VALUE_W-1:0] executed_command;
   logic [2:0]         error_code;
   logic               last;
   modport source(output valid, reply_kind, seen_ballot, executed_slot,
                  executed_command, error_code, last, input ready);
   modport sink(input valid, reply_kind, seen_ballot, executed_slot,
                executed_command, error_code, last, output ready);
endinterface

// ===== rtl/core/pas_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/paxos_acceptor_slot_table.sv =====
`timescale 1ns / 1ps
// Top level of the Multi-Paxos acceptor slot table: sequencer and slot RAM.
// Depends on pas_pkg, pas_if and pas_ram.
//
// One item at a time. A prepare, an accept, an out-of-window message or an
// unknown action takes the transfer cycle, which computes the slot's entry and
// reads the slot RAM, then ST_LOOK, which on the registered read data decides,
// writes the entry back and loads the response register. A commit writes its
// entry in ST_LOOK; the in-order execution walk then reads one RAM entry in
// ST_WALK_RD and checks it in ST_WALK_CHK. Each result is held back
// one step so that its last flag is known. Entries are held in one RAM of
// WINDOW_SLOTS words; a per-entry valid flop makes a fresh or executed entry
// read as zero, so no clearing pass is needed after reset. A new request is
// taken while a response still waits in the output register.
module paxos_acceptor_slot_table #(
   parameter int WINDOW_SLOTS = 64
) (
   input  logic      clock,
   input  logic      reset,
   pas_req_if.sink   req_chan,
   pas_rsp_if.source rsp_chan
);
   import pas_pkg::*;

   localparam int EntryW = $clog2(WINDOW_SLOTS);
   localparam logic [EntryW:0]   WinSize   = (EntryW+1)'(WINDOW_SLOTS);
   localparam logic [EntryW-1:0] LastEntry = EntryW'(WINDOW_SLOTS - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_WALK_RD, ST_WALK_CHK} state_type;

   state_type          state_ff, state_in;
   logic [1:0]         act_ff, act_in;
   logic [VALUE_W-1:0] slot_ff, slot_in;
   logic [VALUE_W-1:0] ballot_ff, ballot_in;
   logic [VALUE_W-1:0] cmd_ff, cmd_in;
   logic               inside_ff, inside_in;
   logic [EntryW-1:0]  entry_ff, entry_in;
   logic [VALUE_W-1:0] hes_ff, hes_in;
   logic [EntryW-1:0]  exec_entry_ff, exec_entry_in;
   logic [WINDOW_SLOTS-1:0] valid_ff, valid_in;
   logic               held_ff, held_in;
   logic [VALUE_W-1:0] held_slot_ff, held_slot_in;
   logic [VALUE_W-1:0] held_cmd_ff, held_cmd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [VALUE_W-1:0] slot_offset;
   logic [EntryW:0]    entry_sum;
   logic [EntryW-1:0]  req_entry;
   logic [EntryW-1:0]  rd_addr;
   logic               wr_en;
   entry_type          wr_data;
   entry_type          rd_data;
   entry_type          cur;
   logic [ENTRY_W-1:0] rd_word;
   logic               out_free;
   logic               walk_hit;

   pas_ram #(.WIDTH(ENTRY_W), .DEPTH(WINDOW_SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (entry_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_data = entry_type'(rd_word);

   // slot entry relative to the entry of the next slot to execute
   assign slot_offset = req_chan.slot - hes_ff - VALUE_W'(1);
   assign entry_sum   = {1'b0, exec_entry_ff} + {1'b0, slot_offset[EntryW-1:0]};
   assign req_entry   = (entry_sum >= WinSize) ? EntryW'(entry_sum - WinSize)
                                               : entry_sum[EntryW-1:0];

   assign rd_addr = (state_ff == ST_IDLE) ? req_entry :
                    (state_ff == ST_LOOK) ? entry_ff : exec_entry_ff;

   assign cur      = valid_ff[entry_ff] ? rd_data : '0;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign walk_hit = valid_ff[exec_entry_ff] && rd_data.committed;

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      slot_in       = slot_ff;
      ballot_in     = ballot_ff;
      cmd_in        = cmd_ff;
      inside_in     = inside_ff;
      entry_in      = entry_ff;
      hes_in        = hes_ff;
      exec_entry_in = exec_entry_ff;
      valid_in      = valid_ff;
      held_in       = held_ff;
      held_slot_in  = held_slot_ff;
      held_cmd_in   = held_cmd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_data       = cur;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               act_in    = req_chan.action;
               slot_in   = req_chan.slot;
               ballot_in = req_chan.ballot;
               cmd_in    = req_chan.command_handle;
               inside_in = (slot_offset < VALUE_W'(WINDOW_SLOTS));
               entry_in  = req_entry;
               state_in  = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (act_ff == ACT_NONE) begin
               state_in = ST_IDLE;
            end else if (!inside_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp(KIND_ERROR, '0, '0, '0,
                                    (act_ff == ACT_COMMIT && slot_ff <= hes_ff) ?
                                    ERR_EXECUTED : ERR_OUT_WINDOW, 1'b1);
                  state_in = ST_IDLE;
               end
            end else if (act_ff == ACT_COMMIT) begin
               wr_en             = 1'b1;
               wr_data.committed = 1'b1;
               wr_data.command   = cmd_ff;
               valid_in[entry_ff] = 1'b1;
               state_in          = ST_WALK_RD;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (act_ff == ACT_PREPARE) begin
                  if (ballot_ff <= cur.seen) begin
                     rsp_in = make_rsp(KIND_ERROR, cur.seen, '0, '0, ERR_STALE, 1'b1);
                  end else begin
                     wr_en              = 1'b1;
                     wr_data.seen       = ballot_ff;
                     valid_in[entry_ff] = 1'b1;
                     rsp_in = make_rsp(KIND_PREPARE, ballot_ff, '0, '0, ERR_NONE, 1'b1);
                  end
               end else if (ballot_ff <= cur.accepted) begin
                  rsp_in = make_rsp(KIND_ERROR, cur.seen, '0, '0, ERR_NOT_ABOVE, 1'b1);
               end else if (ballot_ff < cur.seen) begin
                  rsp_in = make_rsp(KIND_ERROR, cur.seen, '0, '0, ERR_STALE, 1'b1);
               end else begin
                  wr_en              = 1'b1;
                  wr_data.seen       = ballot_ff;
                  wr_data.accepted   = ballot_ff;
                  valid_in[entry_ff] = 1'b1;
                  rsp_in = make_rsp(KIND_ACCEPT, ballot_ff, '0, '0, ERR_NONE, 1'b1);
               end
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_CHK;
         end
         ST_WALK_CHK: begin
            if (walk_hit) begin
               if (!held_ff || out_free) begin
                  if (held_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = make_rsp(KIND_EXEC, '0, held_slot_ff, held_cmd_ff,
                                       ERR_NONE, 1'b0);
                  end
                  held_in       = 1'b1;
                  held_slot_in  = hes_ff + VALUE_W'(1);
                  held_cmd_in   = rd_data.command;
                  valid_in[exec_entry_ff] = 1'b0;
                  hes_in        = hes_ff + VALUE_W'(1);
                  exec_entry_in = (exec_entry_ff == LastEntry) ? '0
                                                               : exec_entry_ff + EntryW'(1);
                  state_in      = ST_WALK_RD;
               end
            end else if (held_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp(KIND_EXEC, '0, held_slot_ff, held_cmd_ff,
                                    ERR_NONE, 1'b1);
                  held_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      slot_ff      <= slot_in;
      ballot_ff    <= ballot_in;
      cmd_ff       <= cmd_in;
      inside_ff    <= inside_in;
      entry_ff     <= entry_in;
      held_slot_ff <= held_slot_in;
      held_cmd_ff  <= held_cmd_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         hes_ff        <= '0;
         exec_entry_ff <= EntryW'(1);
         valid_ff      <= '0;
         held_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hes_ff        <= hes_in;
         exec_entry_ff <= exec_entry_in;
         valid_ff      <= valid_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.reply_kind       = rsp_ff.reply_kind;
   assign rsp_chan.seen_ballot      = rsp_ff.seen_ballot;
   assign rsp_chan.executed_slot    = rsp_ff.executed_slot;
   assign rsp_chan.executed_command = rsp_ff.executed_command;
   assign rsp_chan.error_code       = rsp_ff.error_code;
   assign rsp_chan.last             = rsp_ff.last;
endmodule

// ===== rtl/core/pas_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the acceptor slot table, bound to the top level.
// Depends on pas_pkg.
module pas_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_reply_kind,
   input logic [pas_pkg::VALUE_W-1:0] rsp_seen_ballot,
   input logic [pas_pkg::VALUE_W-1:0] rsp_executed_slot,
   input logic [pas_pkg::VALUE_W-1:0] rsp_executed_command,
   input logic [2:0]                  rsp_error_code,
   input logic                        rsp_last
);
   import pas_pkg::*;

   // one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous still in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_reply_kind,
         rsp_seen_ballot, rsp_executed_slot, rsp_executed_command,
         rsp_error_code, rsp_last}))
      else $error("stalled response changed");

   a_single_reply_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind != KIND_EXEC |-> rsp_last)
      else $error("reply or error without last");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind == KIND_ERROR |->
         rsp_error_code != ERR_NONE && rsp_executed_slot == '0 &&
         rsp_executed_command == '0)
      else $error("malformed error response");

   a_exec_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind == KIND_EXEC |->
         rsp_error_code == ERR_NONE && rsp_seen_ballot == '0)
      else $error("malformed executed command");
endmodule

bind paxos_acceptor_slot_table pas_checker u_pas_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_reply_kind       (rsp_chan.reply_kind),
   .rsp_seen_ballot      (rsp_chan.seen_ballot),
   .rsp_executed_slot    (rsp_chan.executed_slot),
   .rsp_executed_command (rsp_chan.executed_command),
   .rsp_error_code       (rsp_chan.error_code),
   .rsp_last             (rsp_chan.last)
);
